### hdl/intc_pkg.sv
// ---------------------------------------------------------------------------
// Interrupt controller package
// Shared types, register offsets and register-block helper functions.
// ---------------------------------------------------------------------------
package intc_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SRC_W      = 5;
  localparam int unsigned OFFSET_W   = 6;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  // Item kinds carried on the input tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_SRC_SET   = 3'd0,
    KIND_SRC_CLR   = 3'd1,
    KIND_WORD_RD   = 3'd2,
    KIND_WORD_WR   = 3'd3,
    KIND_BYTE_RD   = 3'd4,
    KIND_BYTE_WR   = 3'd5
  } kind_t;

  // Register byte offsets within the block.
  localparam logic [OFFSET_W-1:0] OFF_IRQ_STATUS = 6'h00;
  localparam logic [OFFSET_W-1:0] OFF_MASK       = 6'h04;
  localparam logic [OFFSET_W-1:0] OFF_LEVEL      = 6'h08;
  localparam logic [OFFSET_W-1:0] OFF_CONTROL    = 6'h0C;
  localparam logic [OFFSET_W-1:0] OFF_FIQ_STATUS = 6'h10;
  localparam logic [OFFSET_W-1:0] OFF_PENDING    = 6'h20;

  typedef struct packed {
    kind_t                kind;
    logic [SRC_W-1:0]     source_index;
    logic [OFFSET_W-1:0]  offset;
    logic [DATA_W-1:0]    write_data;
  } item_t;

  typedef struct packed {
    logic                 fiq_line;
    logic                 irq_line;
    logic                 access_error;
    logic [DATA_W-1:0]    read_data;
  } result_t;

  function automatic logic reg_known(input logic [OFFSET_W-1:0] off);
    return (off == OFF_IRQ_STATUS) || (off == OFF_MASK) || (off == OFF_LEVEL) ||
           (off == OFF_CONTROL) || (off == OFF_FIQ_STATUS) || (off == OFF_PENDING);
  endfunction

  function automatic logic [DATA_W-1:0] reg_read(
    input logic [OFFSET_W-1:0] off,
    input logic [DATA_W-1:0]   pending,
    input logic [DATA_W-1:0]   mask,
    input logic [DATA_W-1:0]   level,
    input logic                ctrl
  );
    logic [DATA_W-1:0] val;
    val = '0;
    unique case (off)
      OFF_IRQ_STATUS: val = pending & mask & ~level;
      OFF_MASK:       val = mask;
      OFF_LEVEL:      val = level;
      OFF_CONTROL:    val = {{(DATA_W-1){1'b0}}, ctrl};
      OFF_FIQ_STATUS: val = pending & mask & level;
      OFF_PENDING:    val = pending;
      default:        val = '0;
    endcase
    return val;
  endfunction

endpackage

### hdl/intc_regfile.sv
// ---------------------------------------------------------------------------
// Interrupt controller register file
// Holds pending, mask, level and control state and executes one item.
// ---------------------------------------------------------------------------
module intc_regfile (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            exec_en,
  input  intc_pkg::item_t item,
  output intc_pkg::result_t res
);
  import intc_pkg::*;

  logic [DATA_W-1:0] pending_r, pending_nxt;
  logic [DATA_W-1:0] mask_r, mask_nxt;
  logic [DATA_W-1:0] level_r, level_nxt;
  logic              control_r, control_nxt;

  logic [OFFSET_W-1:0] base_off;
  logic [4:0]          lane_sh;
  logic [DATA_W-1:0]   src_bit;
  logic [DATA_W-1:0]   rd_word;
  logic [DATA_W-1:0]   rd_base;
  logic                wr_en;
  logic [OFFSET_W-1:0] wr_off;
  logic [DATA_W-1:0]   wr_val;

  assign base_off = {item.offset[OFFSET_W-1:2], 2'b00};
  assign lane_sh  = {item.offset[1:0], 3'b000};
  assign src_bit  = {{(DATA_W-1){1'b0}}, 1'b1} << item.source_index;
  assign rd_word  = reg_read(item.offset, pending_r, mask_r, level_r, control_r);
  assign rd_base  = reg_read(base_off, pending_r, mask_r, level_r, control_r);

  always_comb begin
    pending_nxt      = pending_r;
    mask_nxt         = mask_r;
    level_nxt        = level_r;
    control_nxt      = control_r;
    wr_en            = 1'b0;
    wr_off           = item.offset;
    wr_val           = item.write_data;
    res.read_data    = '0;
    res.access_error = 1'b0;

    unique case (item.kind)
      KIND_SRC_SET: pending_nxt = pending_r | src_bit;
      KIND_SRC_CLR: pending_nxt = pending_r & ~src_bit;
      KIND_WORD_RD: begin
        if (reg_known(item.offset)) res.read_data = rd_word;
        else                        res.access_error = 1'b1;
      end
      KIND_WORD_WR: begin
        if (reg_known(item.offset)) wr_en = 1'b1;
        else                        res.access_error = 1'b1;
      end
      KIND_BYTE_RD: begin
        if (reg_known(base_off)) res.read_data = (rd_base >> lane_sh) & 32'h0000_00FF;
        else                     res.access_error = 1'b1;
      end
      KIND_BYTE_WR: begin
        if (reg_known(base_off)) begin
          wr_en  = 1'b1;
          wr_off = base_off;
          wr_val = (rd_base & ~(32'h0000_00FF << lane_sh)) |
                   ({24'd0, item.write_data[7:0]} << lane_sh);
        end else begin
          res.access_error = 1'b1;
        end
      end
      default: ;
    endcase

    // Read-only registers silently ignore writes.
    if (wr_en) begin
      unique case (wr_off)
        OFF_MASK:    mask_nxt    = wr_val;
        OFF_LEVEL:   level_nxt   = wr_val;
        OFF_CONTROL: control_nxt = wr_val[0];
        default: ;
      endcase
    end

    res.irq_line = |(pending_nxt & mask_nxt & ~level_nxt);
    res.fiq_line = |(pending_nxt & mask_nxt & level_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      mask_r    <= '0;
      level_r   <= '0;
      control_r <= 1'b0;
    end else if (exec_en) begin
      pending_r <= pending_nxt;
      mask_r    <= mask_nxt;
      level_r   <= level_nxt;
      control_r <= control_nxt;
    end
  end

endmodule

### hdl/interrupt_controller_regs.sv
// ---------------------------------------------------------------------------
// Interrupt controller register block
// 32-source interrupt controller with pending, mask, level and control state.
// ---------------------------------------------------------------------------
// Usage: every transfer on the input stream is one item. Its kind travels on
// in_tuser: set or clear one source's pending bit, or a word or byte read or
// write at a byte offset in the register block. Every item yields exactly one
// transfer on the output stream carrying the read data, an access error flag
// and the IRQ and FIQ line levels as they stand after the item has acted.
// The item is captured in an input register, executed against the register
// file by a single pass of combinational logic and the result is captured in
// an output register, which drives out_tvalid. An item waits in the input
// register while the output register holds a result not yet taken. One
// item is accepted in every cycle while the output side keeps up; the state
// update happens at the moment an item moves into the output register,
// which keeps the results in order.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more item, after which in_tready falls
// until the output is taken. A synchronous reset clears all interrupt state
// and both pipeline stages; no item is in flight after reset.
// ---------------------------------------------------------------------------
module interrupt_controller_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [4:0] source_index, [10:5] offset, [42:11] write_data, [47:43] zero
  input  logic [intc_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [2:0] kind
  input  logic [intc_pkg::KIND_W-1:0]           in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [31:0] read_data, [32] access_error, [33] irq_line, [34] fiq_line,
  // [39:35] zero
  output logic [intc_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import intc_pkg::*;

  item_t   in_item_r;
  logic    in_valid_r;
  result_t out_res_r;
  logic    out_valid_r;
  result_t exec_res;
  logic    advance;

  // An item moves on when the output register is empty or being drained.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Payload carries no reset; it is qualified by the valid flag.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.kind         <= kind_t'(in_tuser);
      in_item_r.source_index <= in_tdata[SRC_W-1:0];
      in_item_r.offset       <= in_tdata[SRC_W+OFFSET_W-1:SRC_W];
      in_item_r.write_data   <= in_tdata[SRC_W+OFFSET_W+DATA_W-1:SRC_W+OFFSET_W];
    end
  end

  intc_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .exec_en (advance),
    .item    (in_item_r),
    .res     (exec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= exec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DATA_W-3){1'b0}}, out_res_r};

endmodule

### hdl/intc_checker.sv
// ---------------------------------------------------------------------------
// Interrupt controller checker
// Port-level assertions on the interrupt controller register block.
// ---------------------------------------------------------------------------
module intc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [intc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [intc_pkg::KIND_W-1:0]      in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [intc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import intc_pkg::*;

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output result changed while stalled");

  // No result survives a reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A rejected access never returns data.
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[DATA_W] |-> out_tdata[DATA_W-1:0] == '0)
    else $error("read data with access error");

  // With the output side free the block must take input.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled while output is free");

endmodule

bind interrupt_controller_regs intc_checker u_intc_checker (.*);

### bench/interrupt_controller_regs_tb.sv
// ---------------------------------------------------------------------------
// Interrupt controller register block testbench
// Sends set, clear, word and byte register operations into the block over
// the input stream, predicts each result from a local copy of the pending,
// mask, level and control state, and checks every output transfer in order.
// ---------------------------------------------------------------------------
module interrupt_controller_regs_tb;
  import intc_pkg::*;

  // The two kind codes that the block has no meaning for. They must still be
  // accepted, and they must report only the line levels.
  localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd7;

  // An aligned offset with no register behind it.
  localparam logic [OFFSET_W-1:0] OFF_HOLE = 6'h14;

  localparam int unsigned RANDOM_OPS  = 1000;
  localparam int unsigned HOLD_CYCLES = 300;
  // Cycles allowed to pass after the last result, before the final check.
  localparam int unsigned TAIL_CYCLES = 8;
  // Longest quiet stretch is the receiver hold; the limit is several times it.
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [SRC_W-1:0]    src;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   wdata;
    bit                  drain_first;   // wait until the block is empty
  } bus_op_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Operations waiting to be offered, and results predicted for the
  // operations already accepted, oldest first.
  bus_op_t op_queue[$];
  result_t expected_results[$];

  // Local copy of the interrupt state, owned by the driver process.
  logic [DATA_W-1:0] mdl_pending = '0;
  logic [DATA_W-1:0] mdl_mask    = '0;
  logic [DATA_W-1:0] mdl_level   = '0;
  logic              mdl_ctrl    = 1'b0;

  int unsigned ops_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned hold_left    = 0;
  int unsigned holds_done   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned kind_count[8];
  int unsigned error_results = 0;
  int unsigned irq_results   = 0;
  int unsigned fiq_results   = 0;

  bus_op_t     offered_op;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  logic [7:0]  rx_phase   = '0;

  interrupt_controller_regs dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Prediction. A register lookup reports whether the offset names a
  // register at all; a store only touches the three writable registers, so
  // writes to the status and pending registers fall through silently.
  // -------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] peek_reg(input logic [OFFSET_W-1:0] off,
                                                 output logic hit);
    hit = 1'b1;
    case (off)
      OFF_IRQ_STATUS: return mdl_pending & mdl_mask & ~mdl_level;
      OFF_MASK:       return mdl_mask;
      OFF_LEVEL:      return mdl_level;
      OFF_CONTROL:    return {{(DATA_W-1){1'b0}}, mdl_ctrl};
      OFF_FIQ_STATUS: return mdl_pending & mdl_mask & mdl_level;
      OFF_PENDING:    return mdl_pending;
      default: begin
        hit = 1'b0;
        return '0;
      end
    endcase
  endfunction

  function automatic void poke_reg(input logic [OFFSET_W-1:0] off,
                                   input logic [DATA_W-1:0] v);
    case (off)
      OFF_MASK:    mdl_mask  = v;
      OFF_LEVEL:   mdl_level = v;
      OFF_CONTROL: mdl_ctrl  = v[0];
      default: ;
    endcase
  endfunction

  // Applies one operation to the local state and returns what the block
  // should report for it. Both lines reflect the state after the update.
  function automatic result_t predict_intc(input bus_op_t op);
    result_t           r;
    logic              hit;
    logic [OFFSET_W-1:0] base;
    logic [4:0]        sh;
    logic [DATA_W-1:0] cur;
    r    = '0;
    base = {op.offset[OFFSET_W-1:2], 2'b00};
    sh   = {op.offset[1:0], 3'b000};
    kind_count[op.kind]++;
    case (op.kind)
      KIND_SRC_SET: mdl_pending[op.src] = 1'b1;
      KIND_SRC_CLR: mdl_pending[op.src] = 1'b0;
      KIND_WORD_RD: begin
        cur = peek_reg(op.offset, hit);
        if (hit) r.read_data = cur;
        else r.access_error = 1'b1;
      end
      KIND_WORD_WR: begin
        cur = peek_reg(op.offset, hit);
        if (hit) poke_reg(op.offset, op.wdata);
        else r.access_error = 1'b1;
      end
      KIND_BYTE_RD: begin
        cur = peek_reg(base, hit);
        if (hit) r.read_data = (cur >> sh) & 32'hFF;
        else r.access_error = 1'b1;
      end
      KIND_BYTE_WR: begin
        // Read-modify-write of the one lane picked by the low offset bits.
        cur = peek_reg(base, hit);
        if (hit) poke_reg(base, (cur & ~(32'hFF << sh)) | ({24'b0, op.wdata[7:0]} << sh));
        else r.access_error = 1'b1;
      end
      default: ;
    endcase
    r.irq_line = |(mdl_pending & mdl_mask & ~mdl_level);
    r.fiq_line = |(mdl_pending & mdl_mask & mdl_level);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus construction.
  // -------------------------------------------------------------------------
  task automatic add_op(input logic [KIND_W-1:0] kind, input logic [SRC_W-1:0] src,
                        input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] wdata,
                        input bit drain);
    bus_op_t op;
    op.kind        = kind;
    op.src         = src;
    op.offset      = off;
    op.wdata       = wdata;
    op.drain_first = drain;
    op_queue.push_back(op);
  endtask

  function automatic logic [OFFSET_W-1:0] pick_reg_offset();
    case ($urandom_range(0, 5))
      0:       return OFF_IRQ_STATUS;
      1:       return OFF_MASK;
      2:       return OFF_LEVEL;
      3:       return OFF_CONTROL;
      4:       return OFF_FIQ_STATUS;
      default: return OFF_PENDING;
    endcase
  endfunction

  // Mostly well-formed accesses to real registers with random content; the
  // rest are stray offsets and the two reserved kinds.
  task automatic add_random_op(input bit drain);
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] off;
    logic [DATA_W-1:0]   wdata;
    int unsigned         pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)      kind = KIND_SRC_SET;
    else if (pick < 32) kind = KIND_SRC_CLR;
    else if (pick < 50) kind = KIND_WORD_RD;
    else if (pick < 66) kind = KIND_WORD_WR;
    else if (pick < 78) kind = KIND_BYTE_RD;
    else if (pick < 94) kind = KIND_BYTE_WR;
    else kind = $urandom_range(0, 1) ? KIND_RSVD_A : KIND_RSVD_B;

    if ($urandom_range(0, 99) < 85) begin
      off = pick_reg_offset();
      if (kind == KIND_BYTE_RD || kind == KIND_BYTE_WR) off[1:0] = 2'($urandom_range(0, 3));
    end else begin
      off = OFFSET_W'($urandom_range(0, 63));
    end

    case ($urandom_range(0, 7))
      0:       wdata = '0;
      1:       wdata = '1;
      default: wdata = $urandom;
    endcase
    add_op(kind, SRC_W'($urandom_range(0, 31)), off, wdata, drain);
  endtask

  // -------------------------------------------------------------------------
  // Driver. Offers operations in bursts separated by random gaps; gaps are
  // suppressed during the long receiver hold so that the block fills up and
  // stalls its input. An operation marked drain_first is held back until
  // every earlier result has come out.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    bus_op_t op;
    logic    fire;
    fire = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid    <= 1'b0;
      ops_accepted <= 0;
      mdl_pending  = '0;
      mdl_mask     = '0;
      mdl_level    = '0;
      mdl_ctrl     = 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      if (fire) begin
        expected_results.push_back(predict_intc(offered_op));
        ops_accepted <= ops_accepted + 1;
      end
      if (!in_tvalid || fire) begin
        if (gap_left != 0 && hold_left == 0) begin
          gap_left = gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (op_queue.size() == 0 ||
                     (op_queue[0].drain_first && (fire || ops_accepted != results_seen))) begin
          in_tvalid <= 1'b0;
        end else begin
          op         = op_queue.pop_front();
          offered_op = op;
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, op.wdata, op.offset, op.src};
          in_tuser  <= op.kind;
          if (burst_left <= 1) begin
            // Roughly a quarter of bursts run straight into the next one.
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left = burst_left - 1;
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor. Checks every output transfer against the oldest prediction and
  // drives out_tready from a pattern picked by the top two bits of a phase
  // counter: always ready, alternate cycles, and two random duty cycles. Twice
  // during the run it holds off for a long stretch of its own counting.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    logic    rdy;
    if (!rst_n) begin
      out_tready   <= 1'b0;
      results_seen <= 0;
      hold_left    <= 0;
      holds_done   <= 0;
      rx_phase     <= '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(result_t)-1:0];
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Result with nothing expected: data=%h err=%b irq=%b fiq=%b",
                     got.read_data, got.access_error, got.irq_line, got.fiq_line);
        end else begin
          want = expected_results.pop_front();
          if (want.access_error) error_results++;
          if (want.irq_line) irq_results++;
          if (want.fiq_line) fiq_results++;
          if (got.read_data !== want.read_data || got.access_error !== want.access_error ||
              got.irq_line !== want.irq_line || got.fiq_line !== want.fiq_line) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("Mismatch on result %0d: data %h/%h err %b/%b irq %b/%b fiq %b/%b %s",
                       results_seen, got.read_data, want.read_data, got.access_error,
                       want.access_error, got.irq_line, want.irq_line, got.fiq_line,
                       want.fiq_line, "(actual/expected)");
          end
        end
      end

      rx_phase <= rx_phase + 1'b1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (holds_done < 2 && ops_accepted >= (holds_done + 1) * 350) begin
        hold_left  <= HOLD_CYCLES;
        holds_done <= holds_done + 1;
        rdy = 1'b0;
      end else begin
        case (rx_phase[7:6])
          2'd0:    rdy = 1'b1;
          2'd1:    rdy = rx_phase[0];
          2'd2:    rdy = ($urandom_range(0, 99) < 40);
          default: rdy = ($urandom_range(0, 99) < 85);
        endcase
      end
      out_tready <= rdy;
    end
  end

  // Watchdog: a run in which no transfer happens on either side for too long
  // has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Test sequence. The directed part walks the register map from reset:
  // all-ones and all-zero writes, source indexes at both ends, a repeated
  // set and clear, writes to read-only registers, misaligned and unknown
  // word offsets, byte lanes of real and unknown registers, the control
  // register's single bit, and both reserved kinds.
  // -------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < 8; i++) kind_count[i] = 0;

    add_op(KIND_WORD_WR, 5'd0,  OFF_MASK,       32'hFFFF_FFFF, 1'b0);
    add_op(KIND_WORD_WR, 5'd31, OFF_LEVEL,      32'hFFFF_0000, 1'b0);
    add_op(KIND_SRC_SET, 5'd0,  6'h3F,          32'hFFFF_FFFF, 1'b0);
    add_op(KIND_SRC_SET, 5'd31, 6'h00,          32'h0000_0000, 1'b0);
    add_op(KIND_SRC_SET, 5'd16, OFF_MASK,       32'h1234_5678, 1'b0);
    add_op(KIND_SRC_SET, 5'd0,  OFF_LEVEL,      32'h0,         1'b0);
    add_op(KIND_WORD_RD, 5'd0,  OFF_IRQ_STATUS, 32'h0,         1'b0);
    add_op(KIND_WORD_RD, 5'd0,  OFF_FIQ_STATUS, 32'h0,         1'b0);
    add_op(KIND_WORD_RD, 5'd0,  OFF_PENDING,    32'h0,         1'b0);
    add_op(KIND_WORD_WR, 5'd0,  OFF_PENDING,    32'h0000_0000, 1'b0);
    add_op(KIND_WORD_WR, 5'd0,  OFF_IRQ_STATUS, 32'hFFFF_FFFF, 1'b0);
    add_op(KIND_WORD_WR, 5'd0,  OFF_FIQ_STATUS, 32'h0,         1'b0);
    add_op(KIND_WORD_WR, 5'd0,  OFF_CONTROL,    32'hFFFF_FFFF, 1'b0);
    add_op(KIND_WORD_RD, 5'd0,  OFF_CONTROL,    32'h0,         1'b0);
    add_op(KIND_WORD_RD, 5'd0,  6'h06,          32'h0,         1'b0);
    add_op(KIND_WORD_WR, 5'd0,  6'h3F,          32'hFFFF_FFFF, 1'b0);
    add_op(KIND_WORD_RD, 5'd0,  OFF_HOLE,       32'h0,         1'b0);
    add_op(KIND_BYTE_WR, 5'd0,  6'h07,          32'hFFFF_FF00, 1'b0);
    add_op(KIND_BYTE_RD, 5'd0,  6'h07,          32'h0,         1'b0);
    add_op(KIND_BYTE_RD, 5'd0,  6'h23,          32'h0,         1'b0);
    add_op(KIND_BYTE_WR, 5'd0,  6'h0D,          32'h0000_00FF, 1'b0);
    add_op(KIND_BYTE_RD, 5'd0,  6'h3E,          32'h0,         1'b0);
    add_op(KIND_BYTE_WR, 5'd0,  6'h15,          32'h0000_00A5, 1'b0);
    add_op(KIND_SRC_CLR, 5'd31, 6'h00,          32'h0,         1'b0);
    add_op(KIND_SRC_CLR, 5'd31, 6'h00,          32'h0,         1'b0);
    add_op(KIND_RSVD_A,  5'd31, OFF_MASK,       32'hFFFF_FFFF, 1'b0);
    add_op(KIND_RSVD_B,  5'd0,  OFF_PENDING,    32'h0,         1'b0);

    // The random part starts on an empty block, and pauses to let it drain
    // a few more times along the way.
    for (int i = 0; i < RANDOM_OPS; i++)
      add_random_op(i % 250 == 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled away from the rising edge so that the driver's queue updates
    // in the same step cannot be seen half done.
    do @(negedge clk);
    while (op_queue.size() != 0 || in_tvalid || ops_accepted != results_seen);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0d predicted results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end

    $display("Covered %0d operations: %0d set, %0d clear, %0d word, %0d byte, %0d reserved.",
             ops_accepted, kind_count[KIND_SRC_SET], kind_count[KIND_SRC_CLR],
             kind_count[KIND_WORD_RD] + kind_count[KIND_WORD_WR],
             kind_count[KIND_BYTE_RD] + kind_count[KIND_BYTE_WR],
             kind_count[KIND_RSVD_A] + kind_count[KIND_RSVD_B]);
    $display("Checked %0d results: %0d access errors, IRQ high on %0d, FIQ high on %0d.",
             results_seen, error_results, irq_results, fiq_results);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
